[hw/rtl/ktpd_pkg.sv]
// ktpd_pkg: shared types, constants and helpers for the tilt Kalman / PD core.
// No dependencies.
`timescale 1ns / 1ps
package ktpd_pkg;

    localparam int MulW   = 33;           // signed operand width of shared multiplier
    localparam int ProdW  = 2 * MulW;     // product width
    localparam int DenW   = 35;           // divisor width (innovation variance, positive)
    localparam int QuoW   = 62;           // |num| * 2^30 magnitude width
    localparam int FracQ  = 30;

    localparam logic [29:0] SamplePeriodRst = 30'd5368709;
    localparam logic [29:0] AngleNoiseRst   = 30'd1073742;
    localparam logic [29:0] BiasNoiseRst    = 30'd3221225;
    localparam logic [30:0] MeasNoiseRst    = 31'd536870912;
    localparam logic [30:0] ObsGainRst      = 31'd1073741824;
    localparam logic signed [31:0] OneQ30   = 32'sd1073741824;

    typedef enum logic [2:0] {
        REG_SAMPLE_PERIOD = 3'd0,
        REG_ANGLE_NOISE   = 3'd1,
        REG_BIAS_NOISE    = 3'd2,
        REG_MEAS_NOISE    = 3'd3,
        REG_OBS_GAIN      = 3'd4,
        REG_PROP_GAIN     = 3'd5,
        REG_DERIV_GAIN    = 3'd6,
        REG_TARGET        = 3'd7
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE, ST_ISSUE, ST_WB, ST_DIV0, ST_DIV1, ST_DONE
    } t_state;

    // micro-op sequence of one sample
    typedef enum logic [4:0] {
        OP_ANG_PRED  = 5'd0,
        OP_P00_PRED  = 5'd1,
        OP_P01_PRED  = 5'd2,
        OP_P10_PRED  = 5'd3,
        OP_P11_PRED  = 5'd4,
        OP_PCT0      = 5'd5,
        OP_PCT1      = 5'd6,
        OP_INNOV_VAR = 5'd7,
        OP_T1        = 5'd8,
        OP_P00_UPD   = 5'd9,
        OP_P01_UPD   = 5'd10,
        OP_P10_UPD   = 5'd11,
        OP_P11_UPD   = 5'd12,
        OP_ANG_UPD   = 5'd13,
        OP_BIAS_UPD  = 5'd14,
        OP_PROP      = 5'd15,
        OP_DERIV     = 5'd16
    } t_op;

    typedef struct packed {
        logic signed [31:0] accel_angle;
        logic signed [31:0] gyro_rate;
    } t_in;

    typedef struct packed {
        logic signed [31:0] drive;
        logic [30:0]        filtered_angle;
    } t_out;

    typedef struct packed {
        logic               start;
        logic signed [31:0] num;
    } t_div_req;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > 40'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -40'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

[hw/rtl/ktpd_mul.sv]
// ktpd_mul: shared signed multiplier with registered product.
// Depends on ktpd_pkg.
`timescale 1ns / 1ps
module ktpd_mul (
    input  logic                                  i_clk,
    input  logic                                  i_en,
    input  logic signed [ktpd_pkg::MulW-1:0]      i_a,
    input  logic signed [ktpd_pkg::MulW-1:0]      i_b,
    output logic signed [ktpd_pkg::ProdW-1:0]     o_prod
);
    import ktpd_pkg::*;

    logic signed [ProdW-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * i_b;
        end
    end

    assign o_prod = r_prod;

endmodule

[hw/rtl/ktpd_div.sv]
// ktpd_div: restoring divider, sat32(trunc(num * 2^30 / den)), one quotient bit a cycle.
// Depends on ktpd_pkg.
`timescale 1ns / 1ps
module ktpd_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ktpd_pkg::t_div_req            i_req,
    input  logic [ktpd_pkg::DenW-1:0]     i_den,
    output logic                          o_done,
    output logic signed [31:0]            o_quo
);
    import ktpd_pkg::*;

    logic [QuoW-1:0] r_num;
    logic [DenW-1:0] r_rem;
    logic [5:0]      r_cnt;
    logic            r_busy;
    logic            r_done;
    logic            r_neg;
    logic [DenW:0]   trial;
    logic            qbit;
    logic [31:0]     mag;

    assign mag   = i_req.num[31] ? 32'(-i_req.num) : 32'(i_req.num);
    assign trial = {r_rem, r_num[QuoW-1]};
    assign qbit  = (trial >= {1'b0, i_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(QuoW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= {mag, {FracQ{1'b0}}};
            r_rem <= '0;
            r_neg <= i_req.num[31];
        end else if (r_busy) begin
            r_rem <= qbit ? DenW'(trial - {1'b0, i_den}) : trial[DenW-1:0];
            r_num <= {r_num[QuoW-2:0], qbit};
        end
    end

    // saturate signed quotient to 32 bits
    always_comb begin
        if (r_num[QuoW-1:31] != '0)
            o_quo = r_neg ? 32'sh80000000 : 32'sh7fffffff;
        else
            o_quo = r_neg ? -$signed({1'b0, r_num[30:0]}) : $signed({1'b0, r_num[30:0]});
    end

    assign o_done = r_done;

endmodule

[hw/rtl/kalman_tilt_pd_control_core.sv]
// kalman_tilt_pd_control_core: two-state tilt Kalman filter (angle, gyro bias) + PD drive.
// Per sample: 17 multiply ops on the shared multiplier and, when the innovation variance is
// positive, two gain divisions on the shared divider; the result then goes to the output register.
// One sample at a time: the next sample can be accepted in the cycle after the result is loaded,
// and loading waits out any output stall. Throughput is set by the shared multiplier and divider.
// Reset (synchronous, active low): registers to defaults, state zero, covariance identity.
`timescale 1ns / 1ps
module kalman_tilt_pd_control_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // sample input transaction
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ktpd_pkg::t_in      i_in_data,
    // result transaction
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ktpd_pkg::t_out     o_out_data,
    // configuration write
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    import ktpd_pkg::*;

    // configuration
    logic [29:0]        r_dt, r_apn, r_bpn;
    logic [30:0]        r_mn, r_c0;
    logic signed [31:0] r_kp, r_kd, r_target;

    // filter state
    logic signed [31:0] r_ang, r_bias, r_p00, r_p01, r_p10, r_p11;

    // per-sample working registers
    logic signed [31:0] r_accel, r_gyro, r_err, r_pct0, r_pct1, r_t1, r_k0, r_k1;
    logic signed [36:0] r_e;
    logic signed [ProdW-1:0] r_pp;
    logic signed [ProdW:0]   r_diff;

    t_state r_state, n_state;
    t_op    r_op, n_op;

    logic                      r_out_valid;
    t_out                      r_out;

    logic signed [MulW-1:0]    mul_a, mul_b;
    logic signed [ProdW-1:0]   prod;
    logic signed [35:0]        prod_q;     // floor(prod / 2^30)
    logic                      mul_en;
    t_div_req                  div_req;
    logic                      div_done;
    logic signed [31:0]        div_quo;
    logic signed [31:0]        shown;
    logic signed [31:0]        d00;
    logic signed [34:0]        drv_q;
    logic                      in_acc, out_free, e_pos;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign e_pos    = (r_e > 37'sd0);
    assign prod_q   = prod[ProdW-1:FracQ];
    assign shown    = r_ang[31] ? 32'sd0 : r_ang;
    assign d00      = sat32(40'(r_apn) - 40'(r_p01) - 40'(r_p10));

    // ------------------------------------------------------------------ config
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt     <= SamplePeriodRst;
            r_apn    <= AngleNoiseRst;
            r_bpn    <= BiasNoiseRst;
            r_mn     <= MeasNoiseRst;
            r_c0     <= ObsGainRst;
            r_kp     <= '0;
            r_kd     <= '0;
            r_target <= '0;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_SAMPLE_PERIOD: r_dt     <= i_cfg_data[29:0];
                REG_ANGLE_NOISE:   r_apn    <= i_cfg_data[29:0];
                REG_BIAS_NOISE:    r_bpn    <= i_cfg_data[29:0];
                REG_MEAS_NOISE:    r_mn     <= i_cfg_data[30:0];
                REG_OBS_GAIN:      r_c0     <= i_cfg_data[30:0];
                REG_PROP_GAIN:     r_kp     <= i_cfg_data;
                REG_DERIV_GAIN:    r_kd     <= i_cfg_data;
                REG_TARGET:        r_target <= i_cfg_data;
                default:           ;
            endcase
        end
    end

    // ---------------------------------------------------------- shared units
    // operand select for the op being issued
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_op)
            OP_ANG_PRED: begin
                mul_a = 33'(r_gyro) - 33'(r_bias);
                mul_b = 33'(r_dt);
            end
            OP_P00_PRED: begin
                mul_a = 33'(d00);
                mul_b = 33'(r_dt);
            end
            OP_P01_PRED, OP_P10_PRED: begin
                mul_a = -33'(r_p11);
                mul_b = 33'(r_dt);
            end
            OP_P11_PRED: begin
                mul_a = 33'(r_bpn);
                mul_b = 33'(r_dt);
            end
            OP_PCT0:      begin mul_a = 33'(r_c0); mul_b = 33'(r_p00);  end
            OP_PCT1:      begin mul_a = 33'(r_c0); mul_b = 33'(r_p10);  end
            OP_INNOV_VAR: begin mul_a = 33'(r_c0); mul_b = 33'(r_pct0); end
            OP_T1:        begin mul_a = 33'(r_c0); mul_b = 33'(r_p01);  end
            OP_P00_UPD:   begin mul_a = 33'(r_k0); mul_b = 33'(r_pct0); end
            OP_P01_UPD:   begin mul_a = 33'(r_k0); mul_b = 33'(r_t1);   end
            OP_P10_UPD:   begin mul_a = 33'(r_k1); mul_b = 33'(r_pct0); end
            OP_P11_UPD:   begin mul_a = 33'(r_k1); mul_b = 33'(r_t1);   end
            OP_ANG_UPD:   begin mul_a = 33'(r_k0); mul_b = 33'(r_err);  end
            OP_BIAS_UPD:  begin mul_a = 33'(r_k1); mul_b = 33'(r_err);  end
            OP_PROP: begin
                mul_a = 33'(r_kp);
                mul_b = 33'(r_target) - 33'(shown);
            end
            OP_DERIV:     begin mul_a = 33'(r_kd); mul_b = 33'(r_gyro); end
            default:      ;
        endcase
    end

    ktpd_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    ktpd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .i_den   (r_e[DenW-1:0]),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // ----------------------------------------------------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= OP_ANG_PRED;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    always_comb begin
        n_state       = r_state;
        n_op          = r_op;
        mul_en        = 1'b0;
        div_req.start = 1'b0;
        div_req.num   = r_pct0;
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_state = ST_ISSUE;
                    n_op    = OP_ANG_PRED;
                end
            end
            ST_ISSUE: begin
                mul_en  = 1'b1;
                n_state = ST_WB;
            end
            ST_WB: begin
                if (r_op == OP_DERIV) begin
                    n_state = ST_DONE;
                end else if (r_op == OP_T1 && e_pos) begin
                    // gains by division; non-positive variance leaves them zero
                    div_req.start = 1'b1;
                    n_state       = ST_DIV0;
                    n_op          = OP_P00_UPD;
                end else begin
                    n_state = ST_ISSUE;
                    n_op    = t_op'(r_op + 5'd1);
                end
            end
            ST_DIV0: begin
                if (div_done) begin
                    div_req.start = 1'b1;
                    div_req.num   = r_pct1;
                    n_state       = ST_DIV1;
                end
            end
            ST_DIV1: begin
                if (div_done) begin
                    n_state = ST_ISSUE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

    // ------------------------------------------------------------ datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang  <= '0;
            r_bias <= '0;
            r_p00  <= OneQ30;
            r_p01  <= '0;
            r_p10  <= '0;
            r_p11  <= OneQ30;
        end else if (r_state == ST_WB) begin
            case (r_op)
                OP_ANG_PRED: r_ang <= sat32(40'(r_ang) + 40'(prod_q));
                OP_P00_PRED: r_p00 <= sat32(40'(r_p00) + 40'(prod_q));
                OP_P01_PRED: r_p01 <= sat32(40'(r_p01) + 40'(prod_q));
                OP_P10_PRED: r_p10 <= sat32(40'(r_p10) + 40'(prod_q));
                OP_P11_PRED: r_p11 <= sat32(40'(r_p11) + 40'(prod_q));
                OP_P00_UPD:  r_p00 <= sat32(40'(r_p00) - 40'(prod_q));
                OP_P01_UPD:  r_p01 <= sat32(40'(r_p01) - 40'(prod_q));
                OP_P10_UPD:  r_p10 <= sat32(40'(r_p10) - 40'(prod_q));
                OP_P11_UPD:  r_p11 <= sat32(40'(r_p11) - 40'(prod_q));
                OP_ANG_UPD:  r_ang <= sat32(40'(r_ang) + 40'(prod_q));
                OP_BIAS_UPD: r_bias <= sat32(40'(r_bias) + 40'(prod_q));
                default:     ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_accel <= i_in_data.accel_angle;
            r_gyro  <= i_in_data.gyro_rate;
            r_k0    <= '0;
            r_k1    <= '0;
        end
        if (r_state == ST_DIV0 && div_done) r_k0 <= div_quo;
        if (r_state == ST_DIV1 && div_done) r_k1 <= div_quo;
        if (r_state == ST_WB) begin
            case (r_op)
                OP_PCT0: begin
                    r_pct0 <= sat32(40'(prod_q));
                    r_err  <= sat32(40'(r_accel) - 40'(r_ang));
                end
                OP_PCT1:      r_pct1 <= sat32(40'(prod_q));
                OP_INNOV_VAR: r_e    <= 37'(r_mn) + 37'(prod_q);
                OP_T1:        r_t1   <= sat32(40'(prod_q));
                OP_PROP:      r_pp   <= prod;
                OP_DERIV:     r_diff <= 67'(prod) - 67'(r_pp);
                default:      ;
            endcase
        end
    end

    // drive = trunc((kd*gyro - kp*perr) / 2^32), saturated
    always_comb begin
        drv_q = r_diff[ProdW:32];
        if (r_diff[ProdW] && (r_diff[31:0] != '0))
            drv_q = drv_q + 35'sd1;
    end

    // ------------------------------------------------------------ output reg
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_DONE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DONE && out_free) begin
            r_out.drive          <= sat32(40'(drv_q));
            r_out.filtered_angle <= shown[30:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------ assertions
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("input accepted while a sample is in flight");

    a_div_only_pos_var: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> e_pos)
        else $error("gain division started with non-positive variance");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV0 || r_state == ST_DIV1))
        else $error("divider finished outside a division step");

    a_result_after_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_DONE))
        else $error("result raised without finishing a sample");

endmodule

[dv/kalman_tilt_pd_control_core_tb.sv]
// kalman_tilt_pd_control_core_tb: self-checking bench for the tilt Kalman / PD core.
// Depends on ktpd_pkg and kalman_tilt_pd_control_core; a fixed-point filter model
// in the bench predicts every result and a monitor checks them in order.
`timescale 1ns / 1ps
module kalman_tilt_pd_control_core_tb;
    import ktpd_pkg::*;

    localparam longint QOne   = 64'sd1073741824;  // 1.0 in Q2.30
    localparam int     Settle = 400;              // > one sample's worst latency

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   in_valid = 1'b0;
    t_in    in_data = '0;
    logic   out_stall = 1'b0;
    logic   cfg_valid = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic   o_in_stall, o_out_valid, o_cfg_ready;
    t_out   o_out_data;

    kalman_tilt_pd_control_core uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Filter model: register copy and state, updated per accepted sample
    // ------------------------------------------------------------------
    longint dt_q, qa_q, qb_q, rmeas_q, cobs_q, kp_q, kd_q, tgt_q;
    longint ang_est, bias_est;
    longint cov [4];

    t_in    sample_q [$];     // samples waiting to be driven
    t_out   drive_q  [$];     // predicted results, oldest first
    int     n_errors = 0;
    int     n_samples = 0;
    int     n_results = 0;
    int     n_settings = 0;

    function automatic longint clip32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // floor(a*b / 2^30); operands here never exceed 63 bits of product
    function automatic longint mul_q30(input longint a, input longint b);
        return (a * b) >>> 30;
    endfunction

    function automatic void filter_step(input t_in s);
        longint acc, gyr, d00, p0, p1, p2, p3, err, pct0, pct1, e, k0, k1, t1, shown;
        logic signed [127:0] kd_w, kp_w, gy_w, pe_w, sum_w, q_w;
        t_out r;
        acc = s.accel_angle;
        gyr = s.gyro_rate;
        // time update
        ang_est = clip32(ang_est + mul_q30(gyr - bias_est, dt_q));
        d00 = clip32(qa_q - cov[1] - cov[2]);
        p0 = clip32(cov[0] + mul_q30(d00, dt_q));
        p1 = clip32(cov[1] + mul_q30(-cov[3], dt_q));
        p2 = clip32(cov[2] + mul_q30(-cov[3], dt_q));
        p3 = clip32(cov[3] + mul_q30(qb_q, dt_q));
        // measurement update; zero gains when the innovation variance is not positive
        err  = clip32(acc - ang_est);
        pct0 = clip32(mul_q30(cobs_q, p0));
        pct1 = clip32(mul_q30(cobs_q, p2));
        e    = rmeas_q + mul_q30(cobs_q, pct0);
        k0 = 0;
        k1 = 0;
        if (e > 0) begin
            k0 = clip32((pct0 * QOne) / e);
            k1 = clip32((pct1 * QOne) / e);
        end
        t1 = clip32(mul_q30(cobs_q, p1));
        cov[0] = clip32(p0 - mul_q30(k0, pct0));
        cov[1] = clip32(p1 - mul_q30(k0, t1));
        cov[2] = clip32(p2 - mul_q30(k1, pct0));
        cov[3] = clip32(p3 - mul_q30(k1, t1));
        ang_est  = clip32(ang_est + mul_q30(k0, err));
        bias_est = clip32(bias_est + mul_q30(k1, err));
        // PD drive in Q32.32, truncated toward zero; wide math avoids overflow
        shown = (ang_est < 0) ? 0 : ang_est;
        kd_w = kd_q;
        kp_w = kp_q;
        gy_w = gyr;
        pe_w = tgt_q - shown;
        sum_w = kd_w * gy_w - kp_w * pe_w;
        q_w = sum_w / 128'sh1_0000_0000;
        if (q_w > 128'sd2147483647)
            r.drive = 32'sh7fffffff;
        else if (q_w < -128'sd2147483648)
            r.drive = 32'sh80000000;
        else
            r.drive = q_w[31:0];
        r.filtered_angle = shown[30:0];
        drive_q.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // Sample driver: bursts of random length with random gaps
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !o_in_stall) begin
                filter_step(in_data);
                n_samples++;
            end
            if (in_valid && o_in_stall) begin
                // payload held while stalled
            end else if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (sample_q.size() > 0) begin
                in_valid <= 1'b1;
                in_data  <= sample_q.pop_front();
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 8);
                    // a quarter of bursts run back to back, the rest leave gaps
                    // long enough to land anywhere in a sample's work
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 300);
                end else begin
                    burst_left--;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and receiver stall pattern
    // ------------------------------------------------------------------
    int stall_mode = 0;
    int stall_run = 0;

    always @(posedge i_clk) begin
        t_out exp_r;
        if (i_rst_n && o_out_valid && !out_stall) begin
            n_results++;
            if (drive_q.size() == 0) begin
                $error("unexpected result transaction: drive=%0d angle=%0d",
                       o_out_data.drive, o_out_data.filtered_angle);
                n_errors++;
            end else begin
                exp_r = drive_q.pop_front();
                if (o_out_data.drive !== exp_r.drive) begin
                    $error("drive: expected %0d, actual %0d", exp_r.drive, o_out_data.drive);
                    n_errors++;
                end
                if (o_out_data.filtered_angle !== exp_r.filtered_angle) begin
                    $error("filtered_angle: expected %0d, actual %0d",
                           exp_r.filtered_angle, o_out_data.filtered_angle);
                    n_errors++;
                end
            end
        end
        // modes: no stall, light random, heavy random, long solid stalls
        if (stall_run <= 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_run  = $urandom_range(50, 600);
        end
        stall_run--;
        case (stall_mode)
            0: begin
                out_stall <= 1'b0;
            end
            1: begin
                out_stall <= ($urandom_range(0, 3) == 0);
            end
            2: begin
                out_stall <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                out_stall <= (stall_run % 200) < 150;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Configuration and sequencing
    // ------------------------------------------------------------------
    task automatic cfg_write(input t_reg_idx idx, input logic [31:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        // bits above each register's width are dropped by the block
        case (idx)
            REG_SAMPLE_PERIOD: dt_q    = val[29:0];
            REG_ANGLE_NOISE:   qa_q    = val[29:0];
            REG_BIAS_NOISE:    qb_q    = val[29:0];
            REG_MEAS_NOISE:    rmeas_q = val[30:0];
            REG_OBS_GAIN:      cobs_q  = val[30:0];
            REG_PROP_GAIN:     kp_q    = longint'(signed'(val));
            REG_DERIV_GAIN:    kd_q    = longint'(signed'(val));
            default:           tgt_q   = longint'(signed'(val));
        endcase
    endtask

    // block is idle once everything queued went in and every result came back
    task automatic wait_idle();
        while (sample_q.size() > 0 || in_valid || drive_q.size() > 0)
            @(posedge i_clk);
        repeat (Settle) @(posedge i_clk);
    endtask

    task automatic push_sample(input logic [31:0] acc, input logic [31:0] gyr);
        t_in s;
        s.accel_angle = acc;
        s.gyro_rate   = gyr;
        sample_q.push_back(s);
    endtask

    // register value: an extreme, the nominal, fully random, or the nominal with low bits perturbed
    function automatic logic [31:0] pick_reg(input logic [31:0] lo, input logic [31:0] hi,
                                             input logic [31:0] nominal);
        case ($urandom_range(0, 5))
            0: return lo;
            1: return hi;
            2: return nominal;
            3: return $urandom();
            default: return nominal ^ ($urandom() & 32'h000f_ffff);
        endcase
    endfunction

    task automatic random_setting();
        t_reg_idx idx;
        for (int i = 0; i < 8; i++) begin
            idx = t_reg_idx'(i);
            case (idx)
                REG_SAMPLE_PERIOD: cfg_write(idx, pick_reg(0, 32'h3fffffff, 5368709));
                REG_ANGLE_NOISE:   cfg_write(idx, pick_reg(0, 32'h3fffffff, 1073742));
                REG_BIAS_NOISE:    cfg_write(idx, pick_reg(0, 32'h3fffffff, 3221225));
                REG_MEAS_NOISE:    cfg_write(idx, pick_reg(1, 32'h7fffffff, 536870912));
                REG_OBS_GAIN:      cfg_write(idx, pick_reg(0, 32'h7fffffff, 1073741824));
                REG_TARGET:        cfg_write(idx, pick_reg(32'h8000_0000, 32'h7fff_ffff,
                                                           $urandom_range(0, 600000)));
                default:           cfg_write(idx, pick_reg(32'h8000_0000, 32'h7fff_ffff,
                                                           $urandom_range(0, 2000000)));
            endcase
        end
        n_settings++;
    endtask

    initial begin
        logic [31:0] edge_vals [6];
        edge_vals = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff, 32'h1, 32'h0001_0000};

        dt_q = 5368709;
        qa_q = 1073742;
        qb_q = 3221225;
        rmeas_q = 536870912;
        cobs_q = 1073741824;
        kp_q = 0;
        kd_q = 0;
        tgt_q = 0;
        ang_est = 0;
        bias_est = 0;
        cov = '{QOne, 0, 0, QOne};

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        n_settings = 1;

        // directed: reset settings, field extremes, a quiet level stretch
        for (int i = 0; i < 6; i++)
            push_sample(edge_vals[i], edge_vals[5 - i]);
        push_sample(32'd0, 32'd0);
        push_sample(32'd655360, 32'hfff6_0000);
        wait_idle();

        // directed: extreme gains and target, drive saturates both ways
        cfg_write(REG_PROP_GAIN, 32'h7fff_ffff);
        cfg_write(REG_DERIV_GAIN, 32'h8000_0000);
        cfg_write(REG_TARGET, 32'h8000_0000);
        n_settings++;
        for (int i = 0; i < 6; i++)
            push_sample(edge_vals[(i + 2) % 6], edge_vals[i]);
        wait_idle();
        cfg_write(REG_PROP_GAIN, 32'h8000_0000);
        cfg_write(REG_DERIV_GAIN, 32'h7fff_ffff);
        cfg_write(REG_TARGET, 32'h7fff_ffff);
        n_settings++;
        push_sample(32'h8000_0000, 32'h7fff_ffff);
        push_sample(32'h7fff_ffff, 32'h8000_0000);
        wait_idle();

        // directed: zero innovation variance (no correction), widest time step,
        // upper register bits set to show they are ignored
        cfg_write(REG_MEAS_NOISE, 32'h8000_0000);
        cfg_write(REG_OBS_GAIN, 32'h8000_0000);
        cfg_write(REG_SAMPLE_PERIOD, 32'hffff_ffff);
        cfg_write(REG_ANGLE_NOISE, 32'hffff_ffff);
        cfg_write(REG_BIAS_NOISE, 32'hc000_0000);
        n_settings++;
        push_sample(32'h0100_0000, 32'h0001_0000);
        push_sample(32'hff00_0000, 32'hffff_0000);
        push_sample(32'h7fff_ffff, 32'h7fff_ffff);
        wait_idle();

        // random: eight settings, about 85 samples each; mostly plausible tilt
        // and rate values, the rest anything the fields allow
        for (int ph = 0; ph < 8; ph++) begin
            random_setting();
            for (int i = 0; i < 85; i++) begin
                if ($urandom_range(0, 4) != 0)
                    push_sample(32'($signed($urandom_range(0, 11796480)) - 5898240),
                                32'($signed($urandom_range(0, 65536000)) - 32768000));
                else
                    push_sample($urandom(), $urandom());
            end
            wait_idle();
        end

        $display("%0d samples in, %0d results checked, across %0d register settings",
                 n_samples, n_results, n_settings);
        if (n_errors == 0 && drive_q.size() == 0)
            $display("kalman_tilt_pd_control_core: match");
        else
            $display("kalman_tilt_pd_control_core: mismatch");
        $finish;
    end

    // watchdog: several times the slowest correct run
    initial begin
        #30_000_000;
        $display("timeout with %0d results outstanding", drive_q.size());
        $display("kalman_tilt_pd_control_core: mismatch");
        $finish;
    end

endmodule
